// File: rtl/cross_correlation_imaging_stack_unit_macros.svh
// assertion macros used by the checker
`ifndef CROSS_CORRELATION_IMAGING_STACK_UNIT_MACROS_SVH
`define CROSS_CORRELATION_IMAGING_STACK_UNIT_MACROS_SVH

// same-cycle implication, off while in reset
`define CCIS_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off while in reset
`define CCIS_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also covers the reset cycle itself
`define CCIS_AFTER_RESET(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/ccis_pkg.sv
package ccis_pkg;

  // default store sizes
  localparam int WINDOW_POINTS_DEF = 4096;
  localparam int IMAGE_POINTS_DEF  = 16384;

  // depth of the queues on either side of the back part
  localparam int QUEUE_DEPTH = 4;

  // accumulator format, Q17.30
  localparam int ACC_W = 48;
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // function codes of an input beat
  typedef enum logic [1:0] {
    FUNC_CORR  = 2'd0,
    FUNC_STACK = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  // classified operation handed from front to back
  typedef enum logic [1:0] {
    OP_CORR  = 2'd0,
    OP_STACK = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_kind_t;

  typedef struct packed {
    logic [1:0]          func;
    logic [11:0]         point;
    logic [13:0]         image_point;
    logic signed [15:0]  source_sample;
    logic signed [15:0]  receiver_sample;
  } in_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] value;
    logic                    saturated;
  } res_t;

  typedef struct packed {
    op_kind_t            kind;
    logic [11:0]         point;
    logic [13:0]         image_point;
    logic signed [15:0]  s;
    logic signed [15:0]  r;
  } op_t;

  // saturating 48-bit add, clip flag in the top bit
  function automatic logic [ACC_W:0] sat_add(input logic signed [ACC_W-1:0] a,
                                             input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? {1'b1, ACC_MIN} : {1'b1, ACC_MAX};
    end
    return {1'b0, s[ACC_W-1:0]};
  endfunction

endpackage

// File: rtl/ccis_fifo.sv
module ccis_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  T     din,
  output logic full,
  input  logic pop,
  output T     dout,
  output logic empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T               mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  // status and head
  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

// File: rtl/ccis_front.sv
module ccis_front
  import ccis_pkg::*;
#(
  parameter int WINDOW_POINTS = WINDOW_POINTS_DEF,
  parameter int IMAGE_POINTS  = IMAGE_POINTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  in_t  item,
  output logic full,
  input  logic busy,
  input  logic q_pop,
  output op_t  q_op,
  output logic q_valid
);
  op_t  op;
  logic q_full;
  logic q_empty;

  // classify the beat, out-of-range points become no-ops
  always_comb begin
    op.point       = item.point;
    op.image_point = item.image_point;
    op.s           = item.source_sample;
    op.r           = item.receiver_sample;
    op.kind        = OP_NOP;
    if (32'(item.point) < WINDOW_POINTS) begin
      case (item.func)
        FUNC_CORR:  op.kind = OP_CORR;
        FUNC_STACK: op.kind = (32'(item.image_point) < IMAGE_POINTS) ? OP_STACK : OP_NOP;
        FUNC_CLEAR: op.kind = OP_CLEAR;
        default:    op.kind = OP_NOP;
      endcase
    end
  end

  // input queue, closed while the stores are being cleared
  assign full    = q_full || busy;
  assign q_valid = !q_empty;

  ccis_fifo #(.T(op_t), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push && !busy),
    .din   (op),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_op),
    .empty (q_empty)
  );

endmodule

// File: rtl/ccis_comp.sv
module ccis_comp
  import ccis_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [ACC_W-1:0] corr,
  input  logic signed [ACC_W-1:0] se,
  input  logic signed [ACC_W-1:0] re,
  output logic                    done,
  output logic signed [ACC_W-1:0] quot,
  output logic                    sat
);
  localparam int OPW        = ACC_W - 1;
  localparam int HW         = 24;
  localparam int PRW        = 2 * OPW;
  localparam int MUL_STEPS  = 4;
  localparam int SQRT_STEPS = OPW;
  localparam int FRAC       = 30;
  localparam int NUMW       = ACC_W + FRAC;
  localparam int DIV_STEPS  = NUMW;
  localparam int RW         = OPW + 3;

  typedef enum logic [5:0] {
    C_IDLE = 6'b000001,
    C_MUL  = 6'b000010,
    C_SQRT = 6'b000100,
    C_PREP = 6'b001000,
    C_DIV  = 6'b010000,
    C_FIN  = 6'b100000
  } cstate_t;

  cstate_t                 state;
  logic [6:0]              cnt;
  logic [OPW-1:0]          a_op;
  logic [OPW-1:0]          b_op;
  logic                    neg;
  logic [ACC_W-1:0]        mag;
  logic [PRW-1:0]          prod;
  logic [RW-1:0]           rem_s;
  logic [OPW-1:0]          root;
  logic [ACC_W-1:0]        dvs;
  logic [ACC_W-1:0]        rem_d;
  logic [NUMW-1:0]         num;
  logic [ACC_W-1:0]        q;
  logic                    over;

  logic [HW-1:0]           pa;
  logic [HW-1:0]           pb;
  logic [2*HW-1:0]         pp;
  logic [PRW-1:0]          pp_sh;
  logic [RW-1:0]           rem_sh;
  logic [RW-1:0]           trial;
  logic                    sq_ge;
  logic [ACC_W-1:0]        rd_sh;
  logic                    dv_ge;

  // one partial product of the energy product per step
  always_comb begin
    pa    = cnt[1] ? {1'b0, a_op[OPW-1:HW]} : a_op[HW-1:0];
    pb    = cnt[0] ? {1'b0, b_op[OPW-1:HW]} : b_op[HW-1:0];
    pp    = pa * pb;
    pp_sh = {{(PRW-2*HW){1'b0}}, pp};
    case (cnt[1:0])
      2'd0:    pp_sh = pp_sh;
      2'd3:    pp_sh = pp_sh << (2 * HW);
      default: pp_sh = pp_sh << HW;
    endcase
  end

  // square root, one root bit per step
  always_comb begin
    rem_sh = {rem_s[RW-3:0], prod[PRW-1:PRW-2]};
    trial  = {1'b0, root, 2'b01};
    sq_ge  = (rem_sh >= trial);
  end

  // restoring divide, one quotient bit per step
  always_comb begin
    rd_sh = {rem_d[ACC_W-2:0], num[NUMW-1]};
    dv_ge = (rd_sh >= dvs);
  end

  // sign, clip and flag of the quotient
  always_comb begin
    quot = '0;
    sat  = 1'b0;
    if (neg) begin
      if (over || (q > {1'b1, {(ACC_W-1){1'b0}}})) begin
        quot = ACC_MIN;
        sat  = 1'b1;
      end else begin
        quot = $signed(~q + 1'b1);
      end
    end else begin
      if (over || q[ACC_W-1]) begin
        quot = ACC_MAX;
        sat  = 1'b1;
      end else begin
        quot = $signed(q);
      end
    end
  end

  assign done = (state == C_FIN);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        C_IDLE: begin
          if (start) begin
            a_op  <= se[ACC_W-1] ? '0 : se[OPW-1:0];
            b_op  <= re[ACC_W-1] ? '0 : re[OPW-1:0];
            neg   <= corr[ACC_W-1];
            mag   <= corr[ACC_W-1] ? ~corr + 1'b1 : corr;
            prod  <= '0;
            cnt   <= '0;
            state <= C_MUL;
          end
        end
        C_MUL: begin
          prod <= prod + pp_sh;
          if (cnt == 7'(MUL_STEPS - 1)) begin
            cnt   <= 7'(SQRT_STEPS - 1);
            rem_s <= '0;
            root  <= '0;
            state <= C_SQRT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        C_SQRT: begin
          prod  <= prod << 2;
          rem_s <= sq_ge ? rem_sh - trial : rem_sh;
          root  <= {root[OPW-2:0], sq_ge};
          if (cnt == '0) begin
            state <= C_PREP;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        C_PREP: begin
          dvs   <= {1'b0, root} + 1'b1;
          rem_d <= '0;
          num   <= {mag, {FRAC{1'b0}}};
          q     <= '0;
          over  <= 1'b0;
          cnt   <= 7'(DIV_STEPS - 1);
          state <= C_DIV;
        end
        C_DIV: begin
          num   <= num << 1;
          rem_d <= dv_ge ? rd_sh - dvs : rd_sh;
          q     <= {q[ACC_W-2:0], dv_ge};
          over  <= over || (dv_ge && (cnt >= 7'(ACC_W)));
          if (cnt == '0) begin
            state <= C_FIN;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        C_FIN: begin
          state <= C_IDLE;
        end
        default: begin
          state <= C_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/ccis_back.sv
module ccis_back
  import ccis_pkg::*;
#(
  parameter int WINDOW_POINTS = WINDOW_POINTS_DEF,
  parameter int IMAGE_POINTS  = IMAGE_POINTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic compensation_mode,
  input  op_t  q_op,
  input  logic q_valid,
  output logic q_pop,
  output logic busy,
  output logic out_push,
  output res_t out_res,
  input  logic out_full
);
  localparam int WAW  = $clog2(WINDOW_POINTS);
  localparam int IAW  = $clog2(IMAGE_POINTS);
  localparam int MAXP = (WINDOW_POINTS > IMAGE_POINTS) ? WINDOW_POINTS : IMAGE_POINTS;
  localparam int CLW  = $clog2(MAXP) + 1;

  typedef enum logic [2:0] {
    S_RUN  = 3'b001,
    S_COMP = 3'b010,
    S_IMWR = 3'b100
  } bstate_t;

  // stores
  logic signed [ACC_W-1:0] corr_mem [WINDOW_POINTS];
  logic signed [ACC_W-1:0] se_mem   [WINDOW_POINTS];
  logic signed [ACC_W-1:0] re_mem   [WINDOW_POINTS];
  logic signed [ACC_W-1:0] img_mem  [IMAGE_POINTS];
  logic signed [ACC_W-1:0] corr_rd;
  logic signed [ACC_W-1:0] se_rd;
  logic signed [ACC_W-1:0] re_rd;
  logic signed [ACC_W-1:0] img_rd;

  logic                    comp_mode;
  logic                    clearing;
  logic [CLW-1:0]          clr_cnt;
  bstate_t                 state;

  // execute stage
  logic                    a_v;
  op_t                     a_op;
  logic signed [31:0]      p_sr;
  logic signed [31:0]      p_ss;
  logic signed [31:0]      p_rr;

  // last point-store write, for a read that raced it
  logic                    fwd_v;
  logic [WAW-1:0]          fwd_addr;
  logic signed [ACC_W-1:0] fwd_corr;
  logic signed [ACC_W-1:0] fwd_se;
  logic signed [ACC_W-1:0] fwd_re;

  logic signed [ACC_W-1:0] stk_add;
  logic                    stk_sat;

  logic [WAW-1:0]          a_addr;
  logic [IAW-1:0]          a_iaddr;
  logic                    hit;
  logic signed [ACC_W-1:0] corr_cur;
  logic signed [ACC_W-1:0] se_cur;
  logic signed [ACC_W-1:0] re_cur;
  logic [ACC_W:0]          corr_sa;
  logic [ACC_W:0]          se_sa;
  logic [ACC_W:0]          re_sa;
  logic [ACC_W:0]          img_sa;
  logic signed [ACC_W-1:0] corr_new;
  logic signed [ACC_W-1:0] se_new;
  logic signed [ACC_W-1:0] re_new;
  logic                    corr_flag;
  logic                    done_a;
  logic                    a_fire;
  logic                    take;
  logic                    pt_we;
  logic                    img_we;
  logic [WAW-1:0]          pt_ra;
  logic [IAW-1:0]          im_ra;
  logic [WAW-1:0]          pt_wa;
  logic [IAW-1:0]          im_wa;
  logic                    pt_wen;
  logic                    im_wen;
  logic signed [ACC_W-1:0] corr_wd;
  logic signed [ACC_W-1:0] se_wd;
  logic signed [ACC_W-1:0] re_wd;
  logic signed [ACC_W-1:0] img_wd;
  logic                    comp_start;
  logic                    comp_done;
  logic signed [ACC_W-1:0] comp_quot;
  logic                    comp_sat;

  // current store values with forwarding
  always_comb begin
    a_addr   = WAW'(a_op.point);
    a_iaddr  = IAW'(a_op.image_point);
    hit      = fwd_v && (fwd_addr == a_addr);
    corr_cur = hit ? fwd_corr : corr_rd;
    se_cur   = hit ? fwd_se : se_rd;
    re_cur   = hit ? fwd_re : re_rd;
  end

  // correlate and stack arithmetic
  always_comb begin
    corr_sa   = sat_add(corr_cur, {{(ACC_W-32){p_sr[31]}}, p_sr});
    se_sa     = sat_add(se_cur, {{(ACC_W-32){p_ss[31]}}, p_ss});
    re_sa     = sat_add(re_cur, {{(ACC_W-32){p_rr[31]}}, p_rr});
    img_sa    = sat_add(img_rd, stk_add);
    corr_new  = corr_sa[ACC_W-1:0];
    se_new    = comp_mode ? se_sa[ACC_W-1:0] : se_cur;
    re_new    = comp_mode ? re_sa[ACC_W-1:0] : re_cur;
    corr_flag = corr_sa[ACC_W] || (comp_mode && (se_sa[ACC_W] || re_sa[ACC_W]));
  end

  // stage handshake
  always_comb begin
    case (state)
      S_RUN:   done_a = (a_op.kind != OP_STACK);
      S_IMWR:  done_a = 1'b1;
      default: done_a = 1'b0;
    endcase
  end

  assign a_fire     = a_v && done_a && !out_full;
  assign take       = (!a_v || a_fire) && q_valid && !clearing;
  assign q_pop      = take;
  assign busy       = clearing;
  assign out_push   = a_fire;
  assign pt_we      = a_fire && ((a_op.kind == OP_CORR) || (a_op.kind == OP_CLEAR));
  assign img_we     = a_fire && (a_op.kind == OP_STACK);
  assign comp_start = (state == S_RUN) && a_v && (a_op.kind == OP_STACK) && comp_mode;

  // result beat
  always_comb begin
    case (a_op.kind)
      OP_CORR: begin
        out_res.value     = corr_new;
        out_res.saturated = corr_flag;
      end
      OP_STACK: begin
        out_res.value     = img_sa[ACC_W-1:0];
        out_res.saturated = img_sa[ACC_W] || stk_sat;
      end
      default: begin
        out_res.value     = '0;
        out_res.saturated = 1'b0;
      end
    endcase
  end

  // memory port selection, clearing sweep has priority
  always_comb begin
    pt_ra   = take ? WAW'(q_op.point) : a_addr;
    im_ra   = take ? IAW'(q_op.image_point) : a_iaddr;
    pt_wa   = clearing ? WAW'(clr_cnt) : a_addr;
    im_wa   = clearing ? IAW'(clr_cnt) : a_iaddr;
    pt_wen  = clearing ? (clr_cnt < CLW'(WINDOW_POINTS)) : pt_we;
    im_wen  = clearing ? (clr_cnt < CLW'(IMAGE_POINTS)) : img_we;
    corr_wd = (clearing || (a_op.kind == OP_CLEAR)) ? '0 : corr_new;
    se_wd   = (clearing || (a_op.kind == OP_CLEAR)) ? '0 : se_new;
    re_wd   = (clearing || (a_op.kind == OP_CLEAR)) ? '0 : re_new;
    img_wd  = clearing ? '0 : img_sa[ACC_W-1:0];
  end

  // point stores
  always_ff @(posedge clk) begin
    if (pt_wen) begin
      corr_mem[pt_wa] <= corr_wd;
      se_mem[pt_wa]   <= se_wd;
      re_mem[pt_wa]   <= re_wd;
    end
    corr_rd <= corr_mem[pt_ra];
    se_rd   <= se_mem[pt_ra];
    re_rd   <= re_mem[pt_ra];
  end

  // image store
  always_ff @(posedge clk) begin
    if (im_wen) begin
      img_mem[im_wa] <= img_wd;
    end
    img_rd <= img_mem[im_ra];
  end

  // clearing sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      if (clr_cnt == CLW'(MAXP - 1)) begin
        clearing <= 1'b0;
      end
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      comp_mode <= 1'b0;
    end else if (cfg_write) begin
      comp_mode <= compensation_mode;
    end
  end

  // stage register and sample products
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (take) begin
      a_v <= 1'b1;
    end else if (a_fire) begin
      a_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_op <= q_op;
      p_sr <= $signed(q_op.s) * $signed(q_op.r);
      p_ss <= $signed(q_op.s) * $signed(q_op.s);
      p_rr <= $signed(q_op.r) * $signed(q_op.r);
    end
  end

  // forwarding record
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_v <= 1'b0;
    end else if (pt_we) begin
      fwd_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pt_we) begin
      fwd_addr <= a_addr;
      fwd_corr <= corr_wd;
      fwd_se   <= se_wd;
      fwd_re   <= re_wd;
    end
  end

  // stack sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RUN;
    end else begin
      case (state)
        S_RUN: begin
          if (a_v && (a_op.kind == OP_STACK)) begin
            if (comp_mode) begin
              state <= S_COMP;
            end else begin
              stk_add <= corr_cur;
              stk_sat <= 1'b0;
              state   <= S_IMWR;
            end
          end
        end
        S_COMP: begin
          if (comp_done) begin
            stk_add <= comp_quot;
            stk_sat <= comp_sat;
            state   <= S_IMWR;
          end
        end
        S_IMWR: begin
          if (a_fire) begin
            state <= S_RUN;
          end
        end
        default: begin
          state <= S_RUN;
        end
      endcase
    end
  end

  ccis_comp u_comp (
    .clk   (clk),
    .rst   (rst),
    .start (comp_start),
    .corr  (corr_cur),
    .se    (se_cur),
    .re    (re_cur),
    .done  (comp_done),
    .quot  (comp_quot),
    .sat   (comp_sat)
  );

endmodule

// File: rtl/cross_correlation_imaging_stack_unit.sv
// Cross-correlation imaging condition for reverse time migration. Beats enter through a
// queue (push/full) and results leave through a queue (empty/pop), one result per beat,
// in order. Correlate and clear beats run at one per cycle, while the result queue is not
// full, through a single execute stage that reads the three shot stores and writes them
// back when the beat leaves the stage. A stack beat with compensation waits in that stage
// on the iterative unit: 4 partial-product steps for the energy product, 47 square-root
// steps and 78 divide steps. After reset the stores are cleared by a sweep over
// max(WINDOW_POINTS, IMAGE_POINTS) addresses (16384 by default), during which full stays
// high; the compensation register is to be written by the user only while no beat is in
// flight, since queued beats pick up the new mode; nothing in the block enforces this.
module cross_correlation_imaging_stack_unit
  import ccis_pkg::*;
#(
  parameter int WINDOW_POINTS = WINDOW_POINTS_DEF,
  parameter int IMAGE_POINTS  = IMAGE_POINTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  in_t  item,
  output logic empty,
  input  logic pop,
  output res_t result,
  input  logic cfg_write,
  input  logic compensation_mode
);
  op_t  q_op;
  logic q_valid;
  logic q_pop;
  logic busy;
  logic out_push;
  res_t out_res;
  logic out_full;

  // front: accept and classify
  ccis_front #(
    .WINDOW_POINTS (WINDOW_POINTS),
    .IMAGE_POINTS  (IMAGE_POINTS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .item    (item),
    .full    (full),
    .busy    (busy),
    .q_pop   (q_pop),
    .q_op    (q_op),
    .q_valid (q_valid)
  );

  // back: stores and arithmetic
  ccis_back #(
    .WINDOW_POINTS (WINDOW_POINTS),
    .IMAGE_POINTS  (IMAGE_POINTS)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .compensation_mode (compensation_mode),
    .q_op              (q_op),
    .q_valid           (q_valid),
    .q_pop             (q_pop),
    .busy              (busy),
    .out_push          (out_push),
    .out_res           (out_res),
    .out_full          (out_full)
  );

  // result queue
  ccis_fifo #(.T(res_t), .DEPTH(QUEUE_DEPTH)) u_out (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .din   (out_res),
    .full  (out_full),
    .pop   (pop),
    .dout  (result),
    .empty (empty)
  );

endmodule

// File: rtl/ccis_checker.sv
`include "cross_correlation_imaging_stack_unit_macros.svh"

module ccis_checker
  import ccis_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic push,
  input logic full,
  input logic pop,
  input logic empty,
  input res_t result
);
  logic [7:0] outstanding;

  // beats taken in but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + 8'(push && !full) - 8'(pop && !empty);
    end
  end

  `CCIS_AFTER_RESET(a_reset_empty, rst, empty, "result queue not empty after reset")
  `CCIS_AFTER_RESET(a_reset_full, rst, full, "input open during store clearing")
  `CCIS_NEXT(a_result_holds, !empty && !pop, !empty && $stable(result), "waiting result changed")
  `CCIS_HOLDS(a_no_invented, !empty, outstanding != 8'd0, "result without a beat")

endmodule

bind cross_correlation_imaging_stack_unit ccis_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .push   (push),
  .full   (full),
  .pop    (pop),
  .empty  (empty),
  .result (result)
);
